FILE: rtl/bpbs_pkg.sv
`default_nettype none

package bpbs_pkg;

    // Widths fixed by the payload fields
    localparam int CODE_W     = 8;
    localparam int VALUE_W    = 16;
    localparam int FLAGS_W    = 8;
    localparam int CYCLES_W   = 8;
    localparam int RB_CODE_W  = 7;
    localparam int RB_VALUE_W = 14;

    // Command nibbles (high nibble of command_code)
    localparam logic [3:0] CMD_SET   = 4'h1;
    localparam logic [3:0] CMD_RUN   = 4'h2;
    localparam logic [3:0] CMD_HALT  = 4'h3;
    localparam logic [3:0] CMD_QUERY = 4'h4;

    // Readback reply code base, timer select goes in bit 0
    localparam logic [RB_CODE_W-1:0] RB_CODE_BASE = 7'h40;

    // Clamp floors and unit conversion
    localparam logic [VALUE_W-1:0] FAST_US_MIN  = 16'd10;
    localparam logic [VALUE_W-1:0] SLOW_MS_MIN  = 16'd1;
    localparam logic [VALUE_W-1:0] ROUND_US     = 16'd5;
    localparam logic [6:0]         TICKS_PER_MS = 7'd100;

    // x / 10 as (x * 52429) >> 19, exact for x below 262144
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Pulse phases
    localparam logic [1:0] PHASE_POS = 2'd0;
    localparam logic [1:0] PHASE_NEG = 2'd1;
    localparam logic [1:0] PHASE_OFF = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET,
        OP_START,
        OP_STOP,
        OP_READBACK,
        OP_NOP
    } op_kind_t;

    // Decoded command handed from front to back
    typedef struct packed {
        op_kind_t               kind;
        logic                   sel;     // 1 = slow timer
        logic [RB_VALUE_W-1:0]  value;   // clamped period for storage
        logic [FLAGS_W-1:0]     flags;
    } cmd_t;

    typedef struct packed {
        logic dl;
        logic el;
        logic dr;
        logic er;
    } bridge_t;

    localparam bridge_t LINES_OFF = '{dl: 1'b0, el: 1'b0, dr: 1'b0, er: 1'b0};
    localparam bridge_t LINES_POS = '{dl: 1'b1, el: 1'b1, dr: 1'b0, er: 1'b1};
    localparam bridge_t LINES_NEG = '{dl: 1'b0, el: 1'b1, dr: 1'b1, er: 1'b1};

endpackage

`default_nettype wire

FILE: rtl/bpbs_front.sv
`default_nettype none

module bpbs_front
    import bpbs_pkg::*;
#(
    parameter int FAST_US_MAX = 1000,
    parameter int SLOW_MS_MAX = 10000,
    parameter int TICK_W      = 20
) (
    input  wire logic               action,
    input  wire logic [CODE_W-1:0]  command_code,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [FLAGS_W-1:0] flags,
    output cmd_t                    cmd,
    output logic [TICK_W-1:0]       ticks
);

    logic [VALUE_W-1:0] fast_us;
    logic [VALUE_W-1:0] slow_ms;
    logic [VALUE_W:0]   fast_round;
    logic [VALUE_W+16:0] fast_prod;
    logic [VALUE_W+6:0] slow_prod;
    logic [TICK_W-1:0]  fast_ticks;
    logic [TICK_W-1:0]  slow_ticks;
    logic               sel;

    assign sel = command_code[0];

    // Clamp the requested periods
    always_comb begin
        fast_us = value;
        if (value < FAST_US_MIN) begin
            fast_us = FAST_US_MIN;
        end else if (value > VALUE_W'(FAST_US_MAX)) begin
            fast_us = VALUE_W'(FAST_US_MAX);
        end
        slow_ms = value;
        if (value < SLOW_MS_MIN) begin
            slow_ms = SLOW_MS_MIN;
        end else if (value > VALUE_W'(SLOW_MS_MAX)) begin
            slow_ms = VALUE_W'(SLOW_MS_MAX);
        end
    end

    // Convert to 10 us ticks: rounded divide by 10, or times 100
    assign fast_round = {1'b0, fast_us} + {1'b0, ROUND_US};
    assign fast_prod  = {16'd0, fast_round} * {17'd0, DIV10_MUL};
    assign slow_prod  = {7'd0, slow_ms} * {16'd0, TICKS_PER_MS};
    assign fast_ticks = TICK_W'(fast_prod >> DIV10_SHIFT);
    assign slow_ticks = TICK_W'(slow_prod);

    // Classify
    always_comb begin
        cmd.kind  = OP_NOP;
        cmd.sel   = sel;
        cmd.value = sel ? slow_ms[RB_VALUE_W-1:0] : fast_us[RB_VALUE_W-1:0];
        cmd.flags = flags;
        ticks     = sel ? slow_ticks : fast_ticks;
        if (!action) begin
            cmd.kind = OP_TICK;
        end else begin
            case (command_code[CODE_W-1:CODE_W-4])
                CMD_SET:   cmd.kind = OP_SET;
                CMD_RUN:   cmd.kind = OP_START;
                CMD_HALT:  cmd.kind = OP_STOP;
                CMD_QUERY: cmd.kind = OP_READBACK;
                default:   cmd.kind = OP_NOP;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpbs_queue.sv
`default_nettype none

module bpbs_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpbs_back.sv
`default_nettype none

module bpbs_back
    import bpbs_pkg::*;
#(
    parameter int FAST_TICK_W = 7,
    parameter int SLOW_TICK_W = 20,
    parameter int TICK_W      = 20
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire cmd_t                  cmd,
    input  wire logic [TICK_W-1:0]     ticks,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_left_drv,
    output logic                       m_left_ena,
    output logic                       m_right_drv,
    output logic                       m_right_ena,
    output logic                       m_running,
    output logic [CYCLES_W-1:0]        m_cycle_count,
    output logic                       m_readback_valid,
    output logic [RB_CODE_W-1:0]       m_readback_code,
    output logic [RB_VALUE_W-1:0]      m_readback_value,
    output logic [FLAGS_W-1:0]         m_readback_flags
);

    // Sequencer state
    logic                   run_reg, run_next;
    logic                   pending_reg, pending_next;
    logic [1:0]             phase_reg, phase_next;
    logic [FAST_TICK_W-1:0] fast_period_reg, fast_period_next;
    logic [FAST_TICK_W-1:0] fast_cnt_reg, fast_cnt_next;
    logic                   fast_active_reg, fast_active_next;
    logic [SLOW_TICK_W-1:0] slow_period_reg, slow_period_next;
    logic [SLOW_TICK_W-1:0] slow_cnt_reg, slow_cnt_next;
    logic                   slow_active_reg, slow_active_next;
    logic [RB_VALUE_W-1:0]  stored_value_reg [2];
    logic [FLAGS_W-1:0]     stored_flags_reg [2];
    bridge_t                lines_reg, lines_next;
    logic [CYCLES_W-1:0]    cycles_reg, cycles_next;

    // Result register
    logic                   m_valid_reg;
    bridge_t                m_lines_reg;
    logic                   m_running_reg;
    logic [CYCLES_W-1:0]    m_cycles_reg;
    logic                   m_rb_valid_reg;
    logic [RB_CODE_W-1:0]   m_rb_code_reg;
    logic [RB_VALUE_W-1:0]  m_rb_value_reg;
    logic [FLAGS_W-1:0]     m_rb_flags_reg;

    logic                   rb_valid;
    logic [RB_CODE_W-1:0]   rb_code;
    logic [RB_VALUE_W-1:0]  rb_value;
    logic [FLAGS_W-1:0]     rb_flags;

    logic                   fire;
    logic                   fast_counting;
    logic                   slow_counting;
    logic [FAST_TICK_W:0]   fast_inc;
    logic [SLOW_TICK_W:0]   slow_inc;
    logic                   fast_expire;
    logic                   slow_expire;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign fire      = cmd_valid && cmd_ready;

    // Counter increment and expiry detect
    assign fast_counting = fast_active_reg && (fast_period_reg != '0);
    assign slow_counting = slow_active_reg && (slow_period_reg != '0);
    assign fast_inc      = {1'b0, fast_cnt_reg} + {{FAST_TICK_W{1'b0}}, 1'b1};
    assign slow_inc      = {1'b0, slow_cnt_reg} + {{SLOW_TICK_W{1'b0}}, 1'b1};
    assign fast_expire   = fast_counting && (fast_inc >= {1'b0, fast_period_reg});
    assign slow_expire   = slow_counting && (slow_inc >= {1'b0, slow_period_reg});

    // Execute one transaction
    always_comb begin
        run_next         = run_reg;
        pending_next     = pending_reg;
        phase_next       = phase_reg;
        fast_period_next = fast_period_reg;
        fast_cnt_next    = fast_cnt_reg;
        fast_active_next = fast_active_reg;
        slow_period_next = slow_period_reg;
        slow_cnt_next    = slow_cnt_reg;
        slow_active_next = slow_active_reg;
        lines_next       = lines_reg;
        cycles_next      = cycles_reg;
        rb_valid         = 1'b0;
        rb_code          = '0;
        rb_value         = '0;
        rb_flags         = '0;
        case (cmd.kind)
            OP_TICK: begin
                if (fast_counting) begin
                    fast_cnt_next = fast_expire ? '0 : fast_inc[FAST_TICK_W-1:0];
                end
                if (slow_counting) begin
                    slow_cnt_next = slow_expire ? '0 : slow_inc[SLOW_TICK_W-1:0];
                end
                // fast expiry first
                if (fast_expire && run_reg) begin
                    case (phase_reg)
                        PHASE_POS: begin
                            lines_next = LINES_POS;
                            phase_next = PHASE_NEG;
                        end
                        PHASE_NEG: begin
                            lines_next = LINES_NEG;
                            phase_next = PHASE_OFF;
                        end
                        PHASE_OFF: begin
                            lines_next       = LINES_OFF;
                            fast_active_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                // then slow expiry
                if (slow_expire && run_reg) begin
                    phase_next = PHASE_POS;
                    if (pending_reg) begin
                        slow_active_next = 1'b0;
                        run_next         = 1'b0;
                        pending_next     = 1'b0;
                    end else begin
                        cycles_next      = cycles_reg + CYCLES_W'(1);
                        fast_cnt_next    = '0;
                        fast_active_next = 1'b1;
                    end
                end
            end
            OP_SET: begin
                if (cmd.sel) begin
                    slow_period_next = ticks[SLOW_TICK_W-1:0];
                    slow_active_next = 1'b0;
                    slow_cnt_next    = '0;
                end else begin
                    fast_period_next = ticks[FAST_TICK_W-1:0];
                    fast_active_next = 1'b0;
                    fast_cnt_next    = '0;
                end
            end
            OP_START: begin
                if (!run_reg) begin
                    pending_next     = 1'b0;
                    phase_next       = PHASE_POS;
                    fast_cnt_next    = '0;
                    slow_cnt_next    = '0;
                    fast_active_next = 1'b1;
                    slow_active_next = 1'b1;
                    run_next         = 1'b1;
                end
            end
            OP_STOP: begin
                pending_next = 1'b1;
            end
            OP_READBACK: begin
                rb_valid = 1'b1;
                rb_code  = RB_CODE_BASE | {{(RB_CODE_W-1){1'b0}}, cmd.sel};
                rb_value = stored_value_reg[cmd.sel];
                rb_flags = stored_flags_reg[cmd.sel];
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg             <= 1'b0;
            pending_reg         <= 1'b0;
            phase_reg           <= PHASE_POS;
            fast_period_reg     <= '0;
            fast_cnt_reg        <= '0;
            fast_active_reg     <= 1'b0;
            slow_period_reg     <= '0;
            slow_cnt_reg        <= '0;
            slow_active_reg     <= 1'b0;
            stored_value_reg[0] <= '0;
            stored_value_reg[1] <= '0;
            stored_flags_reg[0] <= '0;
            stored_flags_reg[1] <= '0;
            lines_reg           <= LINES_OFF;
            cycles_reg          <= '0;
        end else if (fire) begin
            run_reg         <= run_next;
            pending_reg     <= pending_next;
            phase_reg       <= phase_next;
            fast_period_reg <= fast_period_next;
            fast_cnt_reg    <= fast_cnt_next;
            fast_active_reg <= fast_active_next;
            slow_period_reg <= slow_period_next;
            slow_cnt_reg    <= slow_cnt_next;
            slow_active_reg <= slow_active_next;
            lines_reg       <= lines_next;
            cycles_reg      <= cycles_next;
            if (cmd.kind == OP_SET) begin
                stored_value_reg[cmd.sel] <= cmd.value;
                stored_flags_reg[cmd.sel] <= cmd.flags;
            end
        end
    end

    // Result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_lines_reg    <= lines_next;
            m_running_reg  <= run_next;
            m_cycles_reg   <= cycles_next;
            m_rb_valid_reg <= rb_valid;
            m_rb_code_reg  <= rb_code;
            m_rb_value_reg <= rb_value;
            m_rb_flags_reg <= rb_flags;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_drv       = m_lines_reg.dl;
    assign m_left_ena       = m_lines_reg.el;
    assign m_right_drv      = m_lines_reg.dr;
    assign m_right_ena      = m_lines_reg.er;
    assign m_running        = m_running_reg;
    assign m_cycle_count    = m_cycles_reg;
    assign m_readback_valid = m_rb_valid_reg;
    assign m_readback_code  = m_rb_code_reg;
    assign m_readback_value = m_rb_value_reg;
    assign m_readback_flags = m_rb_flags_reg;

endmodule

`default_nettype wire

FILE: rtl/bipolar_pulse_bridge_sequencer.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  action, command_code, value, flags
// m_        out        m_valid / m_ready  bridge lines, running, cycle_count, readback_*
//
// One transaction per clock when m_ready stays high. The front decodes into a
// two-entry queue and the back executes the queue head into the result register,
// so m_valid rises once the transaction has passed the queue and the result register.
// The execute stage updates all counters and the pulse state together.
// Reset is synchronous, active low, and clears all state but the queue storage and
// the result payload, with no clearing pass. A stalled m_ready holds the result;
// up to two more transactions are queued before s_ready drops.
`default_nettype none

module bipolar_pulse_bridge_sequencer
    import bpbs_pkg::*;
#(
    parameter int FAST_US_MAX = 1000,
    parameter int SLOW_MS_MAX = 10000
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic [CODE_W-1:0]  s_command_code,
    input  wire logic [VALUE_W-1:0] s_value,
    input  wire logic [FLAGS_W-1:0] s_flags,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_left_drv,
    output logic                    m_left_ena,
    output logic                    m_right_drv,
    output logic                    m_right_ena,
    output logic                    m_running,
    output logic [CYCLES_W-1:0]     m_cycle_count,
    output logic                    m_readback_valid,
    output logic [RB_CODE_W-1:0]    m_readback_code,
    output logic [RB_VALUE_W-1:0]   m_readback_value,
    output logic [FLAGS_W-1:0]      m_readback_flags
);

    localparam int FAST_TICK_W = $clog2((FAST_US_MAX + 5) / 10 + 1);
    localparam int SLOW_TICK_W = $clog2(SLOW_MS_MAX * 100 + 1);
    localparam int TICK_W      = (FAST_TICK_W > SLOW_TICK_W) ? FAST_TICK_W : SLOW_TICK_W;
    localparam int Q_W         = $bits(cmd_t) + TICK_W;

    cmd_t              front_cmd;
    logic [TICK_W-1:0] front_ticks;
    cmd_t              back_cmd;
    logic [TICK_W-1:0] back_ticks;
    logic [Q_W-1:0]    q_out;
    logic              q_valid;
    logic              q_ready;

    bpbs_front #(
        .FAST_US_MAX (FAST_US_MAX),
        .SLOW_MS_MAX (SLOW_MS_MAX),
        .TICK_W      (TICK_W)
    ) u_front (
        .action       (s_action),
        .command_code (s_command_code),
        .value        (s_value),
        .flags        (s_flags),
        .cmd          (front_cmd),
        .ticks        (front_ticks)
    );

    bpbs_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  ({front_cmd, front_ticks}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    assign back_cmd   = q_out[Q_W-1:TICK_W];
    assign back_ticks = q_out[TICK_W-1:0];

    bpbs_back #(
        .FAST_TICK_W (FAST_TICK_W),
        .SLOW_TICK_W (SLOW_TICK_W),
        .TICK_W      (TICK_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (q_valid),
        .cmd_ready        (q_ready),
        .cmd              (back_cmd),
        .ticks            (back_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_drv       (m_left_drv),
        .m_left_ena       (m_left_ena),
        .m_right_drv      (m_right_drv),
        .m_right_ena      (m_right_ena),
        .m_running        (m_running),
        .m_cycle_count    (m_cycle_count),
        .m_readback_valid (m_readback_valid),
        .m_readback_code  (m_readback_code),
        .m_readback_value (m_readback_value),
        .m_readback_flags (m_readback_flags)
    );

endmodule

`default_nettype wire
